FILE: rtl/core/rffu_pkg.sv
// rffu_pkg: shared types, widths and tables of the repulsive force field unit
// no dependencies; imported by every module of the block
`default_nettype none

package rffu_pkg;

   // frame capacity and derived widths
   localparam int MAX_POINTS   = 4096;
   localparam int CNT_W        = $clog2(MAX_POINTS) + 1;
   localparam int SUM_W        = $clog2(MAX_POINTS) + 17;
   localparam int NORM_BIT     = 29;
   localparam int NORM_W       = (SUM_W - 1 > NORM_BIT + 1) ? SUM_W - 1 : NORM_BIT + 1;
   localparam int RV_W         = 2 * NORM_W + 2;
   localparam int ROOT_W       = NORM_W + 1;
   localparam int SQRT_STEPS   = NORM_W + 1;
   localparam int FRAC_BITS    = 14;
   localparam int Q_W          = FRAC_BITS + 1;
   localparam int DIV_W        = NORM_W + FRAC_BITS + 1;
   localparam int CORDIC_STEPS = 15;
   localparam int CX_W         = 28;
   localparam int Z_W          = 18;
   localparam int STEP_W       = $clog2(SQRT_STEPS);
   localparam int NEAR_W       = 13;
   localparam int ONE_Q14      = 16384;
   localparam int QUARTER_TURN = 16384;

   // configuration register indexes
   localparam logic [2:0] CSR_RADIUS  = 3'd0;
   localparam logic [2:0] CSR_GAIN    = 3'd1;
   localparam logic [2:0] CSR_LIMIT   = 3'd2;
   localparam logic [2:0] CSR_TOL     = 3'd3;
   localparam logic [2:0] CSR_ALLOWED = 3'd4;

   typedef struct packed {
      logic               new_run;
      logic               point_valid;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic signed [15:0] force_x;
      logic signed [15:0] force_y;
      logic signed [15:0] velocity_x;
      logic signed [15:0] velocity_y;
      logic               area_clear;
      logic               oscillating;
      logic [12:0]        near_points;
   } rsp_type;

   typedef struct packed {
      logic [14:0] neighborhood_radius;
      logic [15:0] velocity_gain;
      logic [14:0] speed_limit;
      logic [15:0] angle_tolerance;
      logic [7:0]  allowed_reversals;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_POINT_SQ,
      OP_POINT_ACC,
      OP_TAIL_LOAD,
      OP_NORM_SHIFT,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQRT_STEP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_VEL_MUL,
      OP_VEL_CLAMP,
      OP_CORDIC_PRE,
      OP_CORDIC_STEP,
      OP_ANGLE,
      OP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [STEP_W-1:0] step;
   } dp_cmd_type;

   typedef struct packed {
      logic last_point;
      logic area_clear;
      logic norm_done;
   } dp_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ,
      ST_ACC,
      ST_TAIL,
      ST_NORM,
      ST_SQX,
      ST_SQY,
      ST_SQRT,
      ST_DIV_INIT,
      ST_DIV,
      ST_VMUL,
      ST_VCLAMP,
      ST_CPRE,
      ST_CORD,
      ST_ANGLE,
      ST_FINISH
   } state_type;

   // arctangent of 2^-i in 1/65536 turn
   function automatic logic [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic [Z_W-1:0] val;
      unique case (idx)
         5'd0:    val = Z_W'(8192);
         5'd1:    val = Z_W'(4836);
         5'd2:    val = Z_W'(2555);
         5'd3:    val = Z_W'(1297);
         5'd4:    val = Z_W'(651);
         5'd5:    val = Z_W'(326);
         5'd6:    val = Z_W'(163);
         5'd7:    val = Z_W'(81);
         5'd8:    val = Z_W'(41);
         5'd9:    val = Z_W'(20);
         5'd10:   val = Z_W'(10);
         5'd11:   val = Z_W'(5);
         5'd12:   val = Z_W'(3);
         5'd13:   val = Z_W'(1);
         5'd14:   val = Z_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rffu_ctrl.sv
// rffu_ctrl: sequencer of the repulsive force field unit
// depends on rffu_pkg; drives rffu_dp through command and status structs
`default_nettype none

module rffu_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   input  rffu_pkg::dp_status_type  status,
   output rffu_pkg::dp_cmd_type     cmd
);
   import rffu_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = OP_NONE;
      cmd.step     = step_ff;
      req_stall    = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.op   = OP_POINT_SQ;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op   = OP_POINT_ACC;
            state_in = status.last_point ? ST_TAIL : ST_IDLE;
         end
         ST_TAIL: begin
            if (status.area_clear) begin
               state_in = ST_FINISH;
            end else begin
               cmd.op   = OP_TAIL_LOAD;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (status.norm_done) begin
               state_in = ST_SQX;
            end else begin
               cmd.op = OP_NORM_SHIFT;
            end
         end
         ST_SQX: begin
            cmd.op   = OP_SQ_X;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.op   = OP_SQ_Y;
            step_in  = STEP_W'(SQRT_STEPS - 1);
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op  = OP_SQRT_STEP;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            step_in  = STEP_W'(Q_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op  = OP_DIV_STEP;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_VMUL;
            end
         end
         ST_VMUL: begin
            cmd.op   = OP_VEL_MUL;
            state_in = ST_VCLAMP;
         end
         ST_VCLAMP: begin
            cmd.op   = OP_VEL_CLAMP;
            state_in = ST_CPRE;
         end
         ST_CPRE: begin
            cmd.op   = OP_CORDIC_PRE;
            step_in  = '0;
            state_in = ST_CORD;
         end
         ST_CORD: begin
            cmd.op  = OP_CORDIC_STEP;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            cmd.op   = OP_ANGLE;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.op       = OP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/core/rffu_dp.sv
// rffu_dp: datapath of the repulsive force field unit
// depends on rffu_pkg; sequenced by rffu_ctrl through dp_cmd_type
`default_nettype none

module rffu_dp (
   input  wire                      clock,
   input  wire                      reset,
   input  rffu_pkg::req_type        req_data,
   input  rffu_pkg::cfg_type        cfg,
   input  rffu_pkg::dp_cmd_type     cmd,
   output rffu_pkg::dp_status_type  status,
   output rffu_pkg::rsp_type        rsp_data
);
   import rffu_pkg::*;

   logic [29:0]            r2_ff;
   req_type                item_ff;
   logic [30:0]            sqx_ff, sqy_ff;
   logic signed [SUM_W-1:0] sum_x_ff, sum_y_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [NORM_W-1:0]      ax_ff, ay_ff;
   logic                   sx_ff, sy_ff;
   logic [RV_W-1:0]        v_ff, r_ff;
   logic [DIV_W-1:0]       rem_x_ff, rem_y_ff;
   logic [Q_W-1:0]         qx_ff, qy_ff;
   logic signed [15:0]     fx_ff, fy_ff;
   logic [Q_W+15:0]        prod_x_ff, prod_y_ff;
   logic signed [15:0]     vx_ff, vy_ff;
   logic signed [CX_W-1:0] cx_ff, cy_ff;
   logic signed [Z_W-1:0]  cz_ff;
   logic [15:0]            prev_angle_ff;
   logic                   known_ff;
   logic [7:0]             rev_ff;
   rsp_type                rsp_ff;

   logic [31:0]            d2;
   logic                   near;
   logic                   clear;
   logic [RV_W-1:0]        bit_w, trial;
   logic [ROOT_W-1:0]      mag;
   logic [DIV_W-1:0]       dshift;
   logic [Q_W-1:0]         qcx, qcy;
   logic [Q_W+16:0]        rnd_x, rnd_y;
   logic [14:0]            vmx, vmy;
   logic signed [CX_W-1:0] cxs, cys, fx_ext, fy_ext;
   logic [15:0]            dang;
   logic [16:0]            aang;

   assign d2    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign near  = d2 < {2'b00, r2_ff};
   assign clear = (sum_x_ff == '0) && (sum_y_ff == '0);
   assign bit_w = RV_W'(1) << {cmd.step, 1'b0};
   assign trial = r_ff + bit_w;
   assign mag   = r_ff[ROOT_W-1:0];
   assign dshift = DIV_W'(mag) << cmd.step;
   assign qcx   = (qx_ff > Q_W'(ONE_Q14)) ? Q_W'(ONE_Q14) : qx_ff;
   assign qcy   = (qy_ff > Q_W'(ONE_Q14)) ? Q_W'(ONE_Q14) : qy_ff;
   assign rnd_x = {1'b0, prod_x_ff} + (Q_W+17)'(1 << 17);
   assign rnd_y = {1'b0, prod_y_ff} + (Q_W+17)'(1 << 17);
   assign cxs   = cx_ff >>> cmd.step;
   assign cys   = cy_ff >>> cmd.step;
   assign fx_ext = CX_W'(fx_ff) <<< 10;
   assign fy_ext = CX_W'(fy_ff) <<< 10;
   assign dang  = cz_ff[15:0] - prev_angle_ff;
   assign aang  = dang[15] ? (17'h10000 - {1'b0, dang}) : {1'b0, dang};

   // velocity magnitude after rounding, clamped to the full 15-bit limit
   always_comb begin
      vmx = ({1'b0, rnd_x[Q_W+16:18]} > cfg.speed_limit) ? cfg.speed_limit
            : 15'(rnd_x[Q_W+16:18]);
      vmy = ({1'b0, rnd_y[Q_W+16:18]} > cfg.speed_limit) ? cfg.speed_limit
            : 15'(rnd_y[Q_W+16:18]);
   end

   always_ff @(posedge clock) begin
      r2_ff <= 30'(cfg.neighborhood_radius * cfg.neighborhood_radius);
   end

   // state that reset clears
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         count_ff      <= '0;
         prev_angle_ff <= '0;
         known_ff      <= 1'b0;
         rev_ff        <= '0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               if (req_data.new_run) begin
                  rev_ff <= '0;
               end
            end
            OP_POINT_ACC: begin
               if (item_ff.point_valid && near && count_ff < CNT_W'(MAX_POINTS)) begin
                  sum_x_ff <= sum_x_ff - SUM_W'(item_ff.point_x);
                  sum_y_ff <= sum_y_ff - SUM_W'(item_ff.point_y);
                  count_ff <= count_ff + 1'b1;
               end
            end
            OP_ANGLE: begin
               if (known_ff) begin
                  if (aang > {1'b0, cfg.angle_tolerance} && rev_ff != 8'hff) begin
                     rev_ff <= rev_ff + 1'b1;
                  end
               end else begin
                  known_ff <= 1'b1;
               end
               prev_angle_ff <= cz_ff[15:0];
            end
            OP_RESULT: begin
               sum_x_ff <= '0;
               sum_y_ff <= '0;
               count_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            item_ff <= req_data;
         end
         OP_POINT_SQ: begin
            sqx_ff <= 31'(item_ff.point_x * item_ff.point_x);
            sqy_ff <= 31'(item_ff.point_y * item_ff.point_y);
         end
         OP_TAIL_LOAD: begin
            ax_ff <= sum_x_ff[SUM_W-1] ? NORM_W'(-sum_x_ff) : NORM_W'(sum_x_ff);
            ay_ff <= sum_y_ff[SUM_W-1] ? NORM_W'(-sum_y_ff) : NORM_W'(sum_y_ff);
            sx_ff <= sum_x_ff[SUM_W-1];
            sy_ff <= sum_y_ff[SUM_W-1];
         end
         OP_NORM_SHIFT: begin
            ax_ff <= ax_ff << 1;
            ay_ff <= ay_ff << 1;
         end
         OP_SQ_X: begin
            v_ff <= RV_W'(ax_ff * ax_ff);
         end
         OP_SQ_Y: begin
            v_ff <= v_ff + RV_W'(ay_ff * ay_ff);
            r_ff <= '0;
         end
         OP_SQRT_STEP: begin
            if (v_ff >= trial) begin
               v_ff <= v_ff - trial;
               r_ff <= (r_ff >> 1) + bit_w;
            end else begin
               r_ff <= r_ff >> 1;
            end
         end
         OP_DIV_INIT: begin
            rem_x_ff <= (DIV_W'(ax_ff) << FRAC_BITS) + DIV_W'(mag >> 1);
            rem_y_ff <= (DIV_W'(ay_ff) << FRAC_BITS) + DIV_W'(mag >> 1);
            qx_ff    <= '0;
            qy_ff    <= '0;
         end
         OP_DIV_STEP: begin
            if (rem_x_ff >= dshift) begin
               rem_x_ff <= rem_x_ff - dshift;
               qx_ff    <= qx_ff | (Q_W'(1) << cmd.step);
            end
            if (rem_y_ff >= dshift) begin
               rem_y_ff <= rem_y_ff - dshift;
               qy_ff    <= qy_ff | (Q_W'(1) << cmd.step);
            end
         end
         OP_VEL_MUL: begin
            fx_ff     <= sx_ff ? -16'(qcx) : 16'(qcx);
            fy_ff     <= sy_ff ? -16'(qcy) : 16'(qcy);
            prod_x_ff <= (Q_W+16)'(qcx * cfg.velocity_gain);
            prod_y_ff <= (Q_W+16)'(qcy * cfg.velocity_gain);
         end
         OP_VEL_CLAMP: begin
            vx_ff <= fx_ff[15] ? -16'(vmx) : 16'(vmx);
            vy_ff <= fy_ff[15] ? -16'(vmy) : 16'(vmy);
         end
         OP_CORDIC_PRE: begin
            if (fx_ext < 0) begin
               if (fy_ext >= 0) begin
                  cx_ff <= fy_ext;
                  cy_ff <= -fx_ext;
                  cz_ff <= Z_W'(QUARTER_TURN);
               end else begin
                  cx_ff <= -fy_ext;
                  cy_ff <= fx_ext;
                  cz_ff <= -Z_W'(QUARTER_TURN);
               end
            end else begin
               cx_ff <= fx_ext;
               cy_ff <= fy_ext;
               cz_ff <= '0;
            end
         end
         OP_CORDIC_STEP: begin
            if (cy_ff > 0) begin
               cx_ff <= cx_ff + cys;
               cy_ff <= cy_ff - cxs;
               cz_ff <= cz_ff + $signed(atan_entry(cmd.step));
            end else if (cy_ff < 0) begin
               cx_ff <= cx_ff - cys;
               cy_ff <= cy_ff + cxs;
               cz_ff <= cz_ff - $signed(atan_entry(cmd.step));
            end
         end
         OP_RESULT: begin
            rsp_ff.force_x     <= clear ? '0 : fx_ff;
            rsp_ff.force_y     <= clear ? '0 : fy_ff;
            rsp_ff.velocity_x  <= clear ? '0 : vx_ff;
            rsp_ff.velocity_y  <= clear ? '0 : vy_ff;
            rsp_ff.area_clear  <= clear;
            rsp_ff.oscillating <= rev_ff > cfg.allowed_reversals;
            rsp_ff.near_points <= NEAR_W'(count_ff);
         end
         default: begin
         end
      endcase
   end

   assign status.last_point = item_ff.last_point;
   assign status.area_clear = clear;
   assign status.norm_done  = (ax_ff[NORM_W-1:NORM_BIT] != '0) ||
                              (ay_ff[NORM_W-1:NORM_BIT] != '0);
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/core/repulsive_force_field_unit_top.sv
// repulsive_force_field_unit_top: top level with configuration registers
// depends on rffu_pkg, rffu_ctrl and rffu_dp
`default_nettype none

// obstacle repulsion unit. one beat on req carries one obstacle point of a frame
// (x, y signed, 1/1024 m); points strictly inside neighborhood_radius are negated
// and summed. the beat with last_point set produces one rsp beat: the unit force
// vector (q14), the velocity scaled by velocity_gain and clamped to speed_limit
// per axis, area_clear when the sum is zero, oscillating when the reversal count
// exceeds allowed_reversals, and the near point count. a point beat is loaded,
// squared, then compared and accumulated. unless the sum is zero, the frame end adds
// a tail: up to 29 normalizing shifts, the bit-serial square root, the restoring
// divider, 15 cordic steps and the fixed steps between them. a new req beat is
// taken while the previous result still waits on rsp. new_run clears the reversal
// count. configuration is written through csr_we/csr_index/csr_wdata; the user
// must do so only while the unit is idle, as the block does not enforce it.
module repulsive_force_field_unit_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  rffu_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output rffu_pkg::rsp_type  rsp_data,
   input  wire                csr_we,
   input  wire  [2:0]         csr_index,
   input  wire  [15:0]        csr_wdata
);
   import rffu_pkg::*;

   cfg_type       cfg_ff;
   dp_cmd_type    cmd;
   dp_status_type status;

   // configuration registers, reset to their default values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neighborhood_radius <= 15'd614;
         cfg_ff.velocity_gain       <= 16'd9830;
         cfg_ff.speed_limit         <= 15'd307;
         cfg_ff.angle_tolerance     <= 16'd29205;
         cfg_ff.allowed_reversals   <= 8'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RADIUS:  cfg_ff.neighborhood_radius <= csr_wdata[14:0];
            CSR_GAIN:    cfg_ff.velocity_gain       <= csr_wdata;
            CSR_LIMIT:   cfg_ff.speed_limit         <= csr_wdata[14:0];
            CSR_TOL:     cfg_ff.angle_tolerance     <= csr_wdata;
            CSR_ALLOWED: cfg_ff.allowed_reversals   <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer: one state per step, a shared step counter for the serial units
   rffu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // accumulators, root, divider, velocity and cordic
   rffu_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

`ifndef SYNTH
   // a clear frame gives no force
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.area_clear |-> rsp_data.force_x == 0 && rsp_data.force_y == 0)
      else $error("clear frame with nonzero force");

   // x velocity stays inside the configured limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.velocity_x <= $signed({1'b0, cfg_ff.speed_limit}) &&
                    rsp_data.velocity_x >= -$signed({1'b0, cfg_ff.speed_limit}))
      else $error("velocity beyond limit");

   // no input beat is taken during the cordic steps of the frame tail
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_CORDIC_STEP |-> req_stall)
      else $error("input taken while busy");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_repulsive_force_field_unit_top.sv
// tb_repulsive_force_field_unit_top: self-checking testbench of the obstacle repulsion unit
// depends on rffu_pkg and repulsive_force_field_unit_top; a local predictor computes each result
`timescale 1ns / 1ps

module tb_repulsive_force_field_unit_top;
   import rffu_pkg::*;

   localparam int IDLE_LIMIT   = 20000;
   localparam int TAIL_CYCLES  = 200;
   localparam int HOLD_CYCLES  = 400;

   logic clock;
   logic reset;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we;
   logic [2:0] csr_index;
   logic [15:0] csr_wdata;

   repulsive_force_field_unit_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // predictor state: a shadow of the configuration and of the frame state
   int unsigned pr_radius, pr_gain, pr_limit, pr_tol, pr_allowed;
   longint      pr_sum_x, pr_sum_y;
   int unsigned pr_near;
   int unsigned pr_prev_angle;
   bit          pr_angle_known;
   int unsigned pr_reversals;
   int          pr_radius_cfg;

   req_type     point_queue[$];   // beats waiting to be driven
   rsp_type     force_expect[$];  // predicted results, oldest first
   int          errors = 0;
   bit          hold_request = 0;

   int          atan_lut[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5,
                                 3, 1, 1};

   // floor shift of a signed value
   function automatic int fshift(int v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic int unsigned heading_of(int fx, int fy);
      int x, y, t, z, xs, ys;
      x = fx * 1024;
      y = fy * 1024;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 16384;
         end else begin
            t = x; x = -y; y = t; z = -16384;
         end
      end
      for (int i = 0; i < 15; i++) begin
         xs = fshift(x, i);
         ys = fshift(y, i);
         if (y > 0) begin
            x = x + ys; y = y - xs; z += atan_lut[i];
         end else if (y < 0) begin
            x = x - ys; y = y + xs; z -= atan_lut[i];
         end
      end
      return z & 32'hFFFF;
   endfunction

   function automatic int scaled_speed(int f);
      longint p, v;
      longint unsigned a;
      p = longint'(f) * longint'(pr_gain);
      a = (p < 0) ? -p : p;
      v = longint'((a + (64'd1 << 17)) >> 18);
      if (p < 0) v = -v;
      if (v > longint'(pr_limit)) v = pr_limit;
      if (v < -longint'(pr_limit)) v = -longint'(pr_limit);
      return int'(v);
   endfunction

   // append one beat to the driver queue
   function automatic void queue_beat(req_type b);
      point_queue.insert(point_queue.size(), b);
   endfunction

   // apply one accepted beat, queue a result on frame end
   function automatic void predict_force(req_type b);
      longint px, py;
      longint unsigned d2, r2, ax, ay, m, mag, q;
      int fx, fy, sd;
      int unsigned ang;
      bit clear;
      rsp_type r;
      if (b.new_run) pr_reversals = 0;
      if (b.point_valid) begin
         px = b.point_x;
         py = b.point_y;
         d2 = px * px + py * py;
         r2 = longint'(pr_radius) * pr_radius;
         if (d2 < r2 && pr_near < MAX_POINTS) begin
            pr_sum_x -= px; pr_sum_y -= py; pr_near++;
         end
      end
      if (!b.last_point) return;
      fx = 0; fy = 0;
      r = '0;
      clear = (pr_sum_x == 0 && pr_sum_y == 0);
      if (!clear) begin
         ax = (pr_sum_x < 0) ? -pr_sum_x : pr_sum_x;
         ay = (pr_sum_y < 0) ? -pr_sum_y : pr_sum_y;
         m = (ax > ay) ? ax : ay;
         while (m < (64'd1 << 29)) begin
            ax <<= 1; ay <<= 1; m <<= 1;
         end
         mag = isqrt(ax * ax + ay * ay);
         q = (ax * 16384 + mag / 2) / mag;
         if (q > 16384) q = 16384;
         fx = (pr_sum_x < 0) ? -int'(q) : int'(q);
         q = (ay * 16384 + mag / 2) / mag;
         if (q > 16384) q = 16384;
         fy = (pr_sum_y < 0) ? -int'(q) : int'(q);
         r.velocity_x = 16'(scaled_speed(fx));
         r.velocity_y = 16'(scaled_speed(fy));
         ang = heading_of(fx, fy);
         if (pr_angle_known) begin
            sd = int'($signed(16'((ang - pr_prev_angle) & 32'hFFFF)));
            if (sd < 0) sd = -sd;
            if (sd > int'(pr_tol) && pr_reversals < 255) pr_reversals++;
         end else begin
            pr_angle_known = 1;
         end
         pr_prev_angle = ang;
      end
      r.force_x = 16'(fx);
      r.force_y = 16'(fy);
      r.area_clear = clear;
      r.oscillating = (pr_reversals > pr_allowed);
      r.near_points = 13'(pr_near);
      force_expect.insert(force_expect.size(), r);
      pr_sum_x = 0; pr_sum_y = 0; pr_near = 0;
   endfunction

   // driver: one beat at a time from point_queue, random gap after each accepted beat
   int gap_left = 0;
   always @(posedge clock) begin
      int gap_draw;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (req_valid && req_stall) begin
         // hold the stalled payload
      end else begin
         gap_draw = gap_left;
         if (req_valid) begin
            void'(point_queue.pop_front());
            gap_draw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
         end
         if (gap_draw > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_draw - 1;
         end else if (point_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= point_queue[0];
            gap_left  <= 0;
         end else begin
            req_valid <= 1'b0;
            gap_left  <= 0;
         end
      end
   end

   // receiver stall: random draw per result, plus a long hold-off on request
   int stall_left = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
      end else if (hold_request && hold_left == 0 && !rsp_stall) begin
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left == 1) begin
         hold_left <= 0;
         rsp_stall <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: predict accepted beats in order, then compare results
   int idle_cycles = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) predict_force(req_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (force_expect.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               errors++;
            end else begin
               want = force_expect.pop_front();
               if (rsp_data.force_x !== want.force_x)
                  $display("%0t: force_x exp %0d got %0d", $time, want.force_x, rsp_data.force_x);
               if (rsp_data.force_y !== want.force_y)
                  $display("%0t: force_y exp %0d got %0d", $time, want.force_y, rsp_data.force_y);
               if (rsp_data.velocity_x !== want.velocity_x)
                  $display("%0t: velocity_x exp %0d got %0d", $time, want.velocity_x,
                           rsp_data.velocity_x);
               if (rsp_data.velocity_y !== want.velocity_y)
                  $display("%0t: velocity_y exp %0d got %0d", $time, want.velocity_y,
                           rsp_data.velocity_y);
               if (rsp_data.area_clear !== want.area_clear)
                  $display("%0t: area_clear exp %0d got %0d", $time, want.area_clear,
                           rsp_data.area_clear);
               if (rsp_data.oscillating !== want.oscillating)
                  $display("%0t: oscillating exp %0d got %0d", $time, want.oscillating,
                           rsp_data.oscillating);
               if (rsp_data.near_points !== want.near_points)
                  $display("%0t: near_points exp %0d got %0d", $time, want.near_points,
                           rsp_data.near_points);
               if (rsp_data !== want) errors++;
            end
         end
         if (idle_cycles > IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // beat builder
   function automatic req_type mk_beat(bit nr, bit pv, int x, int y, bit lp);
      req_type b;
      b.new_run = nr;
      b.point_valid = pv;
      b.point_x = 16'(x);
      b.point_y = 16'(y);
      b.last_point = lp;
      return b;
   endfunction

   // random frame: mostly near points scaled to the radius, some far, some junk
   task automatic queue_frame(int npts);
      int rad, x, y;
      rad = (pr_radius_cfg > 2) ? pr_radius_cfg : 2;
      for (int i = 0; i < npts; i++) begin
         case ($urandom_range(0, 9))
            0: begin
               x = $urandom_range(0, 65535) - 32768;
               y = $urandom_range(0, 65535) - 32768;
            end
            1: begin
               x = 0; y = 0;
            end
            default: begin
               x = $urandom_range(0, rad - 1) - (rad / 2);
               y = $urandom_range(0, rad - 1) - (rad / 2);
            end
         endcase
         queue_beat(mk_beat($urandom_range(0, 40) == 0, $urandom_range(0, 9) != 0,
                            x, y, 1'b0));
      end
      queue_beat(mk_beat($urandom_range(0, 20) == 0, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 255) - 128,
                         $urandom_range(0, 255) - 128, 1'b1));
   endtask

   // register write while idle; shadow updated alongside
   task automatic write_reg(logic [2:0] idx, int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RADIUS:  begin pr_radius = val & 16'h7FFF; pr_radius_cfg = pr_radius; end
         CSR_GAIN:    pr_gain = val & 16'hFFFF;
         CSR_LIMIT:   pr_limit = val & 16'h7FFF;
         CSR_TOL:     pr_tol = val & 16'hFFFF;
         CSR_ALLOWED: pr_allowed = val & 8'hFF;
         default: ;
      endcase
   endtask

   // wait for all beats accepted and results returned, then settle
   task automatic drain();
      while (point_queue.size() > 0 || req_valid || force_expect.size() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   int n_items;
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_RADIUS;
      csr_wdata = '0;
      pr_radius = 614; pr_gain = 9830; pr_limit = 307; pr_tol = 29205; pr_allowed = 0;
      pr_radius_cfg = 614;
      pr_sum_x = 0; pr_sum_y = 0; pr_near = 0;
      pr_prev_angle = 0; pr_angle_known = 0; pr_reversals = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, extremes, empty frames, combined flags
      queue_beat(mk_beat(1'b0, 1'b0, 0, 0, 1'b1));              // empty frame
      queue_beat(mk_beat(1'b0, 1'b1, 100, 0, 1'b1));            // first frame
      queue_beat(mk_beat(1'b0, 1'b1, -100, 0, 1'b1));           // reversal
      queue_beat(mk_beat(1'b0, 1'b1, 0, 200, 1'b0));
      queue_beat(mk_beat(1'b0, 1'b1, 0, -200, 1'b1));           // cancel -> clear
      queue_beat(mk_beat(1'b1, 1'b0, 0, 0, 1'b0));              // only new_run
      queue_beat(mk_beat(1'b1, 1'b1, 50, 50, 1'b1));            // new_run and last
      queue_beat(mk_beat(1'b0, 1'b1, 32767, -32768, 1'b0));     // far
      queue_beat(mk_beat(1'b0, 1'b1, -32768, 32767, 1'b1));
      queue_beat(mk_beat(1'b0, 1'b1, 613, 0, 1'b0));            // on radius edge
      queue_beat(mk_beat(1'b0, 1'b1, 614, 0, 1'b1));
      queue_beat(mk_beat(1'b0, 1'b1, -1, -1, 1'b1));
      drain();
      write_reg(CSR_RADIUS, 32767);
      write_reg(CSR_GAIN, 65535);
      write_reg(CSR_LIMIT, 32767);
      write_reg(CSR_TOL, 0);
      write_reg(CSR_ALLOWED, 255);
      queue_beat(mk_beat(1'b0, 1'b1, 32767, 32767, 1'b0));
      queue_beat(mk_beat(1'b0, 1'b1, -32768, -32768, 1'b1));
      queue_beat(mk_beat(1'b0, 1'b1, -32768, 1, 1'b1));
      queue_beat(mk_beat(1'b0, 1'b1, 1, -32768, 1'b1));
      drain();
      // long frame with zero limit and half-turn tolerance
      write_reg(CSR_LIMIT, 0);
      write_reg(CSR_TOL, 32768);
      for (int i = 0; i < 40; i++)
         queue_beat(mk_beat(1'b0, 1'b1, 5, -3, i == 39));
      drain();

      // random phases over several register settings
      n_items = 0;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_RADIUS, 0); write_reg(CSR_ALLOWED, 0);
               write_reg(CSR_GAIN, 0); write_reg(CSR_LIMIT, 100); write_reg(CSR_TOL, 1000);
            end
            1: begin
               write_reg(CSR_RADIUS, 614); write_reg(CSR_GAIN, 9830);
               write_reg(CSR_LIMIT, 307); write_reg(CSR_TOL, 29205);
            end
            default: begin
               write_reg(CSR_RADIUS, $urandom_range(1, 32767));
               write_reg(CSR_GAIN, $urandom_range(0, 65535));
               write_reg(CSR_LIMIT, $urandom_range(0, 32767));
               write_reg(CSR_TOL, $urandom_range(0, 32768));
               write_reg(CSR_ALLOWED, $urandom_range(0, 4));
            end
         endcase
         while (n_items < (ph + 1) * 150) begin
            int np;
            np = $urandom_range(0, 12);
            queue_frame(np);
            n_items += np + 1;
         end
         // long receiver hold-off once, sender keeps offering
         if (ph == 2) hold_request = 1;
         drain();
         hold_request = 0;
      end

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
